>>> hdl/mtt_pkg.sv
// shared constants, codes and transaction types for the markup tag/text tokenizer
// no dependencies; every other file imports this package
package mtt_pkg;

    localparam int unsigned MAX_TEXT = 4096;
    localparam int unsigned LIMIT_W  = 13;
    localparam int unsigned LEN_W    = 16;
    localparam int unsigned Q_DEPTH  = 4;
    localparam int unsigned Q_AW     = 2;

    // fragment phase codes
    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_TAG  = 2'd1;
    localparam logic [1:0] PH_TEXT = 2'd2;

    // result event codes
    localparam logic [1:0] EV_TEXT  = 2'd0;
    localparam logic [1:0] EV_TAG   = 2'd1;
    localparam logic [1:0] EV_CLOSE = 2'd2;
    localparam logic [1:0] EV_DONE  = 2'd3;

    // fragment kinds
    localparam logic [1:0] KIND_START = 2'd0;
    localparam logic [1:0] KIND_END   = 2'd1;
    localparam logic [1:0] KIND_TEXT  = 2'd2;

    localparam logic MODE_END = 1'b1;

    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_SPACE = 8'h20;

    typedef struct packed {
        logic       mode;
        logic [7:0] char_in;
    } t_item;

    typedef struct packed {
        logic [1:0]       event_res;
        logic [7:0]       char_value;
        logic [1:0]       fragment_kind;
        logic [LEN_W-1:0] fragment_length;
        logic             last;
    } t_res;

    // one queue entry: the results caused by one input item
    typedef struct packed {
        logic two;
        t_res res0;
        t_res res1;
    } t_work;

    function automatic t_res mk_res(input logic [1:0] ev, input logic [7:0] ch,
                                    input logic [1:0] kind, input logic [LEN_W-1:0] len);
        t_res r;
        r.event_res       = ev;
        r.char_value      = ch;
        r.fragment_kind   = kind;
        r.fragment_length = len;
        r.last            = 1'b0;
        return r;
    endfunction

endpackage

>>> hdl/mtt_front.sv
// front end: fragment state, byte classification and result generation
// depends on mtt_pkg; feeds one t_work entry per accepted productive item (byte or end marker) into the queue
module mtt_front
    import mtt_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_accept,
    input  t_item              i_item,
    input  logic               i_cfg_valid,
    input  logic [LIMIT_W-1:0] i_cfg_data,
    output t_work              o_work,
    output logic               o_work_push
);

    logic [1:0]         r_phase, n_phase;
    logic               r_in_quotes, n_in_quotes;
    logic               r_closing, n_closing;
    logic               r_seen6, n_seen6;
    logic               r_prev_space, n_prev_space;
    logic [LEN_W-1:0]   r_run_len, n_run_len;
    logic [LIMIT_W-1:0] r_text_limit;

    logic [LIMIT_W-1:0] v_lim;
    logic [1:0]         v_n;
    t_res               v_r0, v_r1;

    always_comb begin
        if (r_text_limit == '0) begin
            v_lim = LIMIT_W'(1);
        end else if (r_text_limit > LIMIT_W'(MAX_TEXT)) begin
            v_lim = LIMIT_W'(MAX_TEXT);
        end else begin
            v_lim = r_text_limit;
        end
    end

    always_comb begin
        logic [1:0]       ph;
        logic [7:0]       c;
        logic             fresh, do_tag, done;
        logic             q, cl, s6, ps;
        logic [LEN_W-1:0] rl;
        t_res             x;

        n_phase      = r_phase;
        n_in_quotes  = r_in_quotes;
        n_closing    = r_closing;
        n_seen6      = r_seen6;
        n_prev_space = r_prev_space;
        n_run_len    = r_run_len;
        v_n          = 2'd0;
        v_r0         = mk_res(EV_DONE, 8'h00, KIND_START, '0);
        v_r1         = v_r0;
        x            = v_r0;
        c            = i_item.char_in;
        ph           = (r_phase == PH_TAG || r_phase == PH_TEXT) ? r_phase : PH_IDLE;
        done         = 1'b0;
        fresh        = 1'b0;
        do_tag       = 1'b0;
        q            = r_in_quotes;
        cl           = r_closing;
        s6           = r_seen6;
        ps           = r_prev_space;
        rl           = r_run_len;

        if (i_item.mode == MODE_END) begin
            if (ph == PH_TAG) begin
                v_r0 = mk_res(EV_CLOSE, 8'h00, r_closing ? KIND_END : KIND_START, r_run_len);
                v_n  = 2'd1;
            end else if (ph == PH_TEXT) begin
                v_r0 = mk_res(EV_CLOSE, 8'h00, KIND_TEXT, r_run_len);
                v_n  = 2'd1;
            end
            x = mk_res(EV_DONE, 8'h00, KIND_START, '0);
            if (v_n == 2'd0) v_r0 = x; else v_r1 = x;
            v_n          = v_n + 2'd1;
            n_phase      = PH_IDLE;
            n_in_quotes  = 1'b0;
            n_closing    = 1'b0;
            n_seen6      = 1'b0;
            n_prev_space = 1'b0;
            n_run_len    = '0;
        end else begin
            // text meeting '<' closes the text and opens a tag from scratch
            if (ph == PH_TEXT && c == CH_LT) begin
                v_r0 = mk_res(EV_CLOSE, 8'h00, KIND_TEXT, r_run_len);
                v_n  = 2'd1;
            end
            fresh  = !(ph == PH_TAG || (ph == PH_TEXT && c != CH_LT));
            do_tag = (ph == PH_TAG) || (fresh && c == CH_LT);
            q      = fresh ? 1'b0 : r_in_quotes;
            cl     = fresh ? 1'b0 : r_closing;
            s6     = fresh ? 1'b0 : r_seen6;
            ps     = fresh ? 1'b0 : r_prev_space;
            rl     = fresh ? '0 : r_run_len;

            if (do_tag) begin
                x = mk_res(EV_TAG, c, KIND_START, '0);
                if (v_n == 2'd0) v_r0 = x; else v_r1 = x;
                v_n = v_n + 2'd1;
                if (rl != '1) rl = rl + 1'b1;
                if (c == CH_QUOTE) begin
                    q = !q;
                end else if (!q) begin
                    if (c == CH_GT) begin
                        done = 1'b1;
                    end else if (c == CH_SLASH && !s6) begin
                        cl = 1'b1;
                    end
                end
                if (done) begin
                    x = mk_res(EV_CLOSE, 8'h00, cl ? KIND_END : KIND_START, rl);
                    if (v_n == 2'd0) v_r0 = x; else v_r1 = x;
                    v_n = v_n + 2'd1;
                end else begin
                    s6 = s6 | c[6];
                end
                n_phase = done ? PH_IDLE : PH_TAG;
            end else begin
                if (c <= CH_SPACE) begin
                    if (!ps) begin
                        x = mk_res(EV_TEXT, CH_SPACE, KIND_START, '0);
                        if (v_n == 2'd0) v_r0 = x; else v_r1 = x;
                        v_n = v_n + 2'd1;
                        ps  = 1'b1;
                        rl  = rl + 1'b1;
                    end
                end else begin
                    x = mk_res(EV_TEXT, c, KIND_START, '0);
                    if (v_n == 2'd0) v_r0 = x; else v_r1 = x;
                    v_n = v_n + 2'd1;
                    ps  = 1'b0;
                    rl  = rl + 1'b1;
                end
                if (rl >= LEN_W'(v_lim)) begin
                    x = mk_res(EV_CLOSE, 8'h00, KIND_TEXT, rl);
                    if (v_n == 2'd0) v_r0 = x; else v_r1 = x;
                    v_n  = v_n + 2'd1;
                    done = 1'b1;
                end
                n_phase = done ? PH_IDLE : PH_TEXT;
            end

            n_in_quotes  = done ? 1'b0 : q;
            n_closing    = done ? 1'b0 : cl;
            n_seen6      = done ? 1'b0 : s6;
            n_prev_space = done ? 1'b0 : ps;
            n_run_len    = done ? '0 : rl;
        end

        if (v_n == 2'd1) v_r0.last = 1'b1;
        if (v_n == 2'd2) v_r1.last = 1'b1;
    end

    assign o_work.two  = (v_n == 2'd2);
    assign o_work.res0 = v_r0;
    assign o_work.res1 = v_r1;
    assign o_work_push = i_accept && (v_n != 2'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_in_quotes  <= 1'b0;
            r_closing    <= 1'b0;
            r_seen6      <= 1'b0;
            r_prev_space <= 1'b0;
            r_run_len    <= '0;
            r_text_limit <= LIMIT_W'(MAX_TEXT);
        end else begin
            if (i_accept) begin
                r_phase      <= n_phase;
                r_in_quotes  <= n_in_quotes;
                r_closing    <= n_closing;
                r_seen6      <= n_seen6;
                r_prev_space <= n_prev_space;
                r_run_len    <= n_run_len;
            end
            if (i_cfg_valid) begin
                r_text_limit <= i_cfg_data;
            end
        end
    end

`ifndef SYNTHESIS
    a_last_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_work_push |-> (o_work.two ? (!o_work.res0.last && o_work.res1.last)
                                    : o_work.res0.last))
        else $error("last flag misplaced in queue entry");

    a_text_within_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && r_phase == PH_TEXT) |=> (r_run_len < LEN_W'(v_lim)))
        else $error("open text fragment reached its limit without closing");

    a_idle_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_IDLE) |-> (r_run_len == '0 && !r_in_quotes && !r_closing))
        else $error("fragment state left over between fragments");
`endif

endmodule

>>> hdl/mtt_queue.sv
// short queue of t_work entries between front and back end
// depends on mtt_pkg for the entry type and depth
module mtt_queue
    import mtt_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_work i_wdata,
    input  logic  i_pop,
    output t_work o_rdata,
    output logic  o_full,
    output logic  o_empty
);

    t_work           r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wp, r_rp;
    logic [Q_AW:0]   r_cnt;

    assign o_full  = (r_cnt == (Q_AW+1)'(Q_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_rdata = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 1'b1;
            if (i_pop)  r_rp <= r_rp + 1'b1;
            unique case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push)
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_empty |-> !i_pop)
        else $error("pop from empty queue");

    a_count_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_full |-> (r_cnt[Q_AW-1:0] == Q_AW'(r_wp - r_rp)))
        else $error("queue count out of step with pointers");
`endif

endmodule

>>> hdl/mtt_back.sv
// back end: unpacks queue entries into single results and holds the output register
// depends on mtt_pkg
module mtt_back
    import mtt_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_work i_work,
    input  logic  i_q_empty,
    output logic  o_q_pop,
    input  logic  i_pop,
    output t_res  o_result,
    output logic  o_empty
);

    logic r_valid, n_valid;
    logic r_sub, n_sub;
    t_res r_out, n_out;

    always_comb begin
        n_valid = r_valid;
        n_sub   = r_sub;
        n_out   = r_out;
        o_q_pop = 1'b0;
        // output slot frees when empty or taken this cycle
        if (!r_valid || i_pop) begin
            if (!i_q_empty) begin
                n_valid = 1'b1;
                if (i_work.two && !r_sub) begin
                    n_out = i_work.res0;
                    n_sub = 1'b1;
                end else begin
                    n_out   = r_sub ? i_work.res1 : i_work.res0;
                    n_sub   = 1'b0;
                    o_q_pop = 1'b1;
                end
            end else begin
                n_valid = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_sub   <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_sub   <= n_sub;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_result = r_out;
    assign o_empty  = !r_valid;

`ifndef SYNTHESIS
    a_sub_has_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sub |-> (!i_q_empty && i_work.two))
        else $error("second result pending without its queue entry");

    a_sub_after_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sub |-> (r_valid && !r_out.last))
        else $error("first of two results flagged last");

    a_pop_only_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop |=> r_valid)
        else $error("queue entry dropped without a result");
`endif

endmodule

>>> hdl/markup_tag_text_tokenizer_core.sv
// a byte accepted is written into the queue, then loaded into the output register
// throughput: one input byte per cycle while the queue is not full; results leave one per cycle
// through the single output register while pop is held, so a byte that gives two results holds
// that port for both of them and the four-entry queue between the front and back ends absorbs such bursts
// reset (synchronous, active low): between fragments, queue and output empty,
// text_limit back to 4096
module markup_tag_text_tokenizer_core
    import mtt_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    input  t_item              i_item,
    output logic               full,
    output logic               empty,
    input  logic               pop,
    output t_res               o_result,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [LIMIT_W-1:0] i_cfg_data
);

    logic  accept;
    t_work work_in, work_out;
    logic  work_push, q_pop, q_full, q_empty;

    assign accept      = push && !q_full;
    assign full        = q_full;
    assign o_cfg_ready = 1'b1;

    mtt_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_item      (i_item),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .o_work      (work_in),
        .o_work_push (work_push)
    );

    mtt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (work_push),
        .i_wdata (work_in),
        .i_pop   (q_pop),
        .o_rdata (work_out),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    mtt_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_work    (work_out),
        .i_q_empty (q_empty),
        .o_q_pop   (q_pop),
        .i_pop     (pop),
        .o_result  (o_result),
        .o_empty   (empty)
    );

endmodule

>>> dv/markup_tag_text_tokenizer_core_tb.sv
// self-checking testbench for markup_tag_text_tokenizer_core: byte stream in, token stream out
// depends on mtt_pkg (item/result structs, codes) and the core itself; nothing else
`timescale 1ns / 100ps

module markup_tag_text_tokenizer_core_tb;
    import mtt_pkg::*;

    localparam logic        MODE_BYTE     = 1'b0;
    localparam int unsigned GAP_MAX       = 13;
    localparam int unsigned SETTLE_CYCLES = 8;
    localparam int unsigned DRAIN_LIMIT   = 4000;
    localparam int unsigned HOLD_CYCLES   = 80;
    localparam int unsigned PHASE_ITEMS   = 80;
    localparam int unsigned LONG_TEXT     = 40;

    logic               i_clk;
    logic               i_rst_n;
    logic               push;
    t_item              i_item;
    logic               full;
    logic               empty;
    logic               pop;
    t_res               o_result;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic [LIMIT_W-1:0] i_cfg_data;

    markup_tag_text_tokenizer_core uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .i_item      (i_item),
        .full        (full),
        .empty       (empty),
        .pop         (pop),
        .o_result    (o_result),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    // tokenizer state as the block should hold it
    logic [LIMIT_W-1:0] text_limit_reg;
    logic [1:0]         frag_phase;
    logic               quote_open;
    logic               is_end_tag;
    logic [7:0]         tag_bits_seen;
    logic               space_run_open;
    logic [LEN_W-1:0]   frag_len;

    t_res expected_tokens[$];
    t_res step_tokens[$];

    int unsigned errors;
    int unsigned items_sent;
    int unsigned n_start_tags;
    int unsigned n_end_tags;
    int unsigned n_texts;
    int unsigned n_finish;
    bit          no_gaps;
    int unsigned pop_wait;
    int unsigned hold_req;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #8_000_000;
        $display("timeout at %0t", $time);
        $display("markup_tag_text_tokenizer_core: mismatch");
        $finish;
    end

    // ---------------- token prediction ----------------

    function automatic logic [LEN_W-1:0] effective_limit();
        if (text_limit_reg == '0)
            return LEN_W'(1);
        else if (text_limit_reg > MAX_TEXT)
            return LEN_W'(MAX_TEXT);
        return LEN_W'(text_limit_reg);
    endfunction

    task automatic clear_fragment();
        frag_phase     = PH_IDLE;
        quote_open     = 1'b0;
        is_end_tag     = 1'b0;
        tag_bits_seen  = '0;
        space_run_open = 1'b0;
        frag_len       = '0;
    endtask

    task automatic emit(logic [1:0] ev, logic [7:0] ch, logic [1:0] kind, logic [LEN_W-1:0] len);
        t_res r;
        r.event_res       = ev;
        r.char_value      = ch;
        r.fragment_kind   = kind;
        r.fragment_length = len;
        r.last            = 1'b0;
        step_tokens.push_back(r);
    endtask

    task automatic predict_tag_byte(logic [7:0] c);
        bit closed;
        closed = 1'b0;
        emit(EV_TAG, c, '0, '0);
        if (frag_len != '1)
            frag_len++;
        if (c == CH_QUOTE) begin
            quote_open = ~quote_open;
        end else if (!quote_open) begin
            if (c == CH_GT)
                closed = 1'b1;
            else if (c == CH_SLASH && !tag_bits_seen[6])
                is_end_tag = 1'b1;
        end
        if (closed) begin
            emit(EV_CLOSE, '0, is_end_tag ? KIND_END : KIND_START, frag_len);
            clear_fragment();
        end else begin
            tag_bits_seen |= c;
        end
    endtask

    task automatic predict_text_byte(logic [7:0] c);
        if (c <= CH_SPACE) begin
            // runs of space-class bytes collapse into one space
            if (!space_run_open) begin
                emit(EV_TEXT, CH_SPACE, '0, '0);
                space_run_open = 1'b1;
                frag_len++;
            end
        end else begin
            emit(EV_TEXT, c, '0, '0);
            space_run_open = 1'b0;
            frag_len++;
        end
        if (frag_len >= effective_limit()) begin
            emit(EV_CLOSE, '0, KIND_TEXT, frag_len);
            clear_fragment();
        end
    endtask

    task automatic predict_tokens(t_item it);
        step_tokens.delete();
        if (it.mode == MODE_END) begin
            if (frag_phase == PH_TAG)
                emit(EV_CLOSE, '0, is_end_tag ? KIND_END : KIND_START, frag_len);
            else if (frag_phase == PH_TEXT)
                emit(EV_CLOSE, '0, KIND_TEXT, frag_len);
            emit(EV_DONE, '0, '0, '0);
            clear_fragment();
        end else begin
            // text meeting a tag opener closes first, then the tag opens
            if (frag_phase == PH_TEXT && it.char_in == CH_LT) begin
                emit(EV_CLOSE, '0, KIND_TEXT, frag_len);
                clear_fragment();
            end
            if (frag_phase == PH_TAG) begin
                predict_tag_byte(it.char_in);
            end else if (frag_phase == PH_TEXT) begin
                predict_text_byte(it.char_in);
            end else begin
                clear_fragment();
                if (it.char_in == CH_LT) begin
                    frag_phase = PH_TAG;
                    predict_tag_byte(it.char_in);
                end else begin
                    frag_phase = PH_TEXT;
                    predict_text_byte(it.char_in);
                end
            end
        end
        if (step_tokens.size() != 0)
            step_tokens[step_tokens.size() - 1].last = 1'b1;
        foreach (step_tokens[k])
            expected_tokens.push_back(step_tokens[k]);
    endtask

    // ---------------- result side ----------------

    initial begin : result_drain
        pop <= 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req != 0) begin
                pop_wait = hold_req;
                hold_req = 0;
            end
            if (pop_wait != 0) begin
                pop <= 1'b0;
                pop_wait--;
            end else begin
                pop <= 1'b1;
            end
        end
    end

    task automatic check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            errors++;
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin : result_check
        t_res want;
        if (i_rst_n && pop && !empty) begin
            if (expected_tokens.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none, got %h", $time, o_result);
            end else begin
                want = expected_tokens.pop_front();
                check_field("event_res", want.event_res, o_result.event_res);
                check_field("char_value", want.char_value, o_result.char_value);
                check_field("fragment_kind", want.fragment_kind, o_result.fragment_kind);
                check_field("fragment_length", want.fragment_length, o_result.fragment_length);
                check_field("last", want.last, o_result.last);
                if (want.event_res == EV_DONE)
                    n_finish++;
                else if (want.event_res == EV_CLOSE && want.fragment_kind == KIND_START)
                    n_start_tags++;
                else if (want.event_res == EV_CLOSE && want.fragment_kind == KIND_END)
                    n_end_tags++;
                else if (want.event_res == EV_CLOSE)
                    n_texts++;
            end
            pop_wait = no_gaps ? 0 : $urandom_range(0, GAP_MAX);
        end
    end

    // ---------------- input side ----------------

    task automatic send_item(logic m, logic [7:0] c);
        t_item it;
        int unsigned gap;
        it.mode    = m;
        it.char_in = c;
        gap = no_gaps ? 0 : $urandom_range(0, GAP_MAX);
        repeat (gap) begin
            @(negedge i_clk);
            push <= 1'b0;
        end
        @(negedge i_clk);
        push   <= 1'b1;
        i_item <= it;
        @(posedge i_clk);
        while (full)
            @(posedge i_clk);
        predict_tokens(it);
        items_sent++;
    endtask

    task automatic send_string(string s);
        for (int k = 0; k < s.len(); k++)
            send_item(MODE_BYTE, s[k]);
    endtask

    task automatic wait_all_results();
        int unsigned guard;
        guard = 0;
        @(negedge i_clk);
        push <= 1'b0;
        while (expected_tokens.size() != 0 && guard < DRAIN_LIMIT) begin
            @(posedge i_clk);
            guard++;
        end
        if (expected_tokens.size() != 0) begin
            $display("%0t: %0d results expected, got none", $time, expected_tokens.size());
            errors += expected_tokens.size();
            expected_tokens.delete();
        end
        // a collapsed space gives no result; let the block settle before going on
        repeat (SETTLE_CYCLES)
            @(posedge i_clk);
    endtask

    task automatic write_text_limit(logic [LIMIT_W-1:0] v);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        text_limit_reg = v;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [7:0] name_char();
        return 8'h61 + 8'($urandom_range(0, 25));
    endfunction

    function automatic logic [7:0] quoted_char();
        case ($urandom_range(0, 3))
            0:       return CH_GT;
            1:       return CH_SLASH;
            2:       return CH_LT;
            default: return name_char();
        endcase
    endfunction

    function automatic logic [7:0] text_char();
        logic [7:0] c;
        case ($urandom_range(0, 9))
            0, 1:    c = 8'($urandom_range(0, 32));
            2:       c = 8'($urandom_range(128, 255));
            default: c = 8'($urandom_range(33, 126));
        endcase
        return (c == CH_LT) ? name_char() : c;
    endfunction

    task automatic send_random_fragment();
        int unsigned pick;
        int unsigned n;
        pick = $urandom_range(0, 19);
        if (pick < 7) begin
            send_item(MODE_BYTE, CH_LT);
            n = $urandom_range(1, 5);
            repeat (n) send_item(MODE_BYTE, name_char());
            if ($urandom_range(0, 1)) begin
                send_item(MODE_BYTE, CH_SPACE);
                send_item(MODE_BYTE, name_char());
                send_item(MODE_BYTE, "=");
                send_item(MODE_BYTE, CH_QUOTE);
                n = $urandom_range(0, 4);
                repeat (n) send_item(MODE_BYTE, quoted_char());
                send_item(MODE_BYTE, CH_QUOTE);
            end
            if ($urandom_range(0, 3) == 0)
                send_item(MODE_BYTE, CH_SLASH);
            send_item(MODE_BYTE, CH_GT);
        end else if (pick < 10) begin
            send_item(MODE_BYTE, CH_LT);
            send_item(MODE_BYTE, CH_SLASH);
            n = $urandom_range(1, 5);
            repeat (n) send_item(MODE_BYTE, name_char());
            send_item(MODE_BYTE, CH_GT);
        end else if (pick < 16) begin
            n = $urandom_range(1, 14);
            repeat (n) send_item(MODE_BYTE, text_char());
        end else if (pick < 18) begin
            n = $urandom_range(1, 4);
            repeat (n) send_item(MODE_BYTE, 8'($urandom_range(0, 255)));
        end else if (pick == 18) begin
            // malformed tag, possibly left open
            send_item(MODE_BYTE, CH_LT);
            n = $urandom_range(0, 6);
            repeat (n) send_item(MODE_BYTE, $urandom_range(0, 1) ? quoted_char()
                                                                 : 8'($urandom_range(0, 255)));
        end else begin
            send_item(MODE_END, 8'($urandom_range(0, 255)));
        end
    endtask

    // ---------------- tests ----------------

    task automatic test_fragment_cases();
        send_string("</x>");
        send_string("<p \">/\">");
        send_string("< />");
        send_item(MODE_BYTE, "a");
        send_item(MODE_BYTE, 8'h09);
        send_item(MODE_BYTE, 8'h0A);
        send_item(MODE_BYTE, 8'hFF);
        send_item(MODE_BYTE, CH_LT);
        send_item(MODE_END, 8'hFF);
        send_item(MODE_END, 8'h00);
        send_item(MODE_BYTE, 8'h00);
        send_item(MODE_END, 8'h7F);
        wait_all_results();
    endtask

    task automatic test_text_limit();
        int unsigned n;
        write_text_limit('0);
        send_string("ab");
        wait_all_results();
        write_text_limit(LIMIT_W'(3));
        send_string("abc d");
        send_item(MODE_END, 8'h00);
        wait_all_results();
        // above the ceiling: behaves as the maximum, one long fragment
        no_gaps = 1'b1;
        write_text_limit('1);
        n = LONG_TEXT;
        repeat (n) send_item(MODE_BYTE, name_char());
        send_item(MODE_END, 8'h00);
        wait_all_results();
        write_text_limit(LIMIT_W'(MAX_TEXT));
        write_text_limit(LIMIT_W'(1));
        send_string(" x");
        wait_all_results();
        no_gaps = 1'b0;
    endtask

    task automatic test_full_backpressure();
        no_gaps = 1'b1;
        @(posedge i_clk);
        hold_req = HOLD_CYCLES;
        send_item(MODE_BYTE, CH_LT);
        repeat (38) send_item(MODE_BYTE, name_char());
        send_item(MODE_BYTE, CH_GT);
        no_gaps = 1'b0;
        // sender stays quiet until every result is out
        wait_all_results();
        send_string("hi<b>");
        send_item(MODE_END, 8'h00);
        wait_all_results();
    endtask

    task automatic test_random_streams();
        int unsigned target;
        for (int ph = 0; ph < 7; ph++) begin
            case (ph)
                0:       write_text_limit(LIMIT_W'(1));
                2:       write_text_limit('0);
                4:       write_text_limit('1);
                6:       write_text_limit(LIMIT_W'(MAX_TEXT));
                default: write_text_limit(LIMIT_W'($urandom_range(2, 24)));
            endcase
            no_gaps = ($urandom_range(0, 3) == 0);
            target  = items_sent + PHASE_ITEMS;
            while (items_sent < target)
                send_random_fragment();
            wait_all_results();
        end
        no_gaps = 1'b0;
    endtask

    initial begin : main_seq
        errors       = 0;
        items_sent   = 0;
        n_start_tags = 0;
        n_end_tags   = 0;
        n_texts      = 0;
        n_finish     = 0;
        no_gaps      = 1'b0;
        pop_wait     = 0;
        hold_req     = 0;
        text_limit_reg = LIMIT_W'(MAX_TEXT);
        clear_fragment();
        i_rst_n     <= 1'b0;
        push        <= 1'b0;
        i_item      <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_data  <= '0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_fragment_cases();
        test_text_limit();
        test_full_backpressure();
        test_random_streams();
        wait_all_results();

        $display("%0d bytes and end markers sent; closed %0d start tags, %0d end tags,",
                 items_sent, n_start_tags, n_end_tags);
        $display("%0d text fragments, %0d end-of-input reports, limits 0/1/3/4096/8191 and random",
                 n_texts, n_finish);
        if (errors == 0)
            $display("markup_tag_text_tokenizer_core: match");
        else
            $display("markup_tag_text_tokenizer_core: mismatch");
        $finish;
    end

endmodule

>>> filelist.f
hdl/mtt_pkg.sv
hdl/mtt_front.sv
hdl/mtt_queue.sv
hdl/mtt_back.sv
hdl/markup_tag_text_tokenizer_core.sv
dv/markup_tag_text_tokenizer_core_tb.sv
